[rtl/mlsba_pkg.sv]
// Shared constants for the multichannel linear scale and block average block.
`default_nettype none
package mlsba_pkg;

  // Channel storage depth and field widths.
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CH_W             = 3;
  localparam int CODE_W           = 12;
  localparam int PCT_W            = 8;
  localparam int SUM_W            = 16;
  localparam int TOTAL_W          = 11;
  localparam int COUNT_W          = 4;
  localparam int LEN_W            = 8;
  localparam int COEF_W           = 32;
  localparam int CFG_IDX_W        = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W        = 16;
  localparam int OUT_DATA_W       = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 2'd3;

  // Register values after reset.
  localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd1;
  localparam logic [LEN_W-1:0]   RST_AVG_LENGTH    = 8'd1;
  localparam logic [COEF_W-1:0]  RST_GAIN          = 32'h0001_0000;
  localparam logic [COEF_W-1:0]  RST_OFFSET        = 32'h0000_0000;

  // Saturation limits.
  localparam logic [PCT_W-1:0] PERCENT_CAP = 8'd255;
  localparam logic [SUM_W-1:0] SUM_CAP     = 16'hFFFF;

endpackage
`default_nettype wire

[rtl/multichannel_linear_scale_block_average.sv]
// Top level: per-channel linear scaling, block averaging and all-channel means.
//
// Usage: each input transaction carries one 12-bit converter sample and its
// channel index (in_tdata: channel, then sample_code). Samples arrive in
// rounds in channel order; channel channel_count-1 closes a round. Every
// input transaction yields exactly one output transaction with the scaled
// percent value, the channel average, and the means over the configured
// channels; out_tuser flags a freshly completed channel average.
//
// Sequencing: one item at a time goes through a small sequencer around one
// 32x13 multiplier and one shared restoring divider (16 steps per division).
// An item passes through scaling and update, a division of the channel sum
// when it completes an average, a totaling pass over the configured
// channels, the divisions for the two means and the load of the output
// register. in_tready is high only while the sequencer is idle, so a new
// item is taken only once the previous one is in the output register.
//
// Reset (rst_n low, synchronous) restores the register defaults and clears
// all channel values, sums, averages and the round counter. When the
// receiver stalls, the finished result waits in the output register; the
// next item is still accepted and processed, and it waits at its end until
// the output register frees up.
`default_nettype none
module multichannel_linear_scale_block_average #(
  parameter int MAX_CHANNELS = mlsba_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input stream. in_tdata fields from bit 0: channel[2:0], sample_code[14:3].
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [mlsba_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream. out_tdata fields from bit 0: channel_out[2:0],
  // last_value[10:3], channel_average[18:11], all_last_mean[26:19],
  // all_average_mean[34:27]. out_tuser fields from bit 0: average_updated.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [mlsba_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                      out_tuser,
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic [mlsba_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [mlsba_pkg::COEF_W-1:0]         cfg_wdata
);

  localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_W    = mlsba_pkg::CH_W;
  localparam int PCT_W   = mlsba_pkg::PCT_W;
  localparam int SUM_W   = mlsba_pkg::SUM_W;
  localparam int TOT_W   = mlsba_pkg::TOTAL_W;
  localparam int CNT_W   = mlsba_pkg::COUNT_W;
  localparam int LEN_W   = mlsba_pkg::LEN_W;
  localparam int COEF_W  = mlsba_pkg::COEF_W;
  localparam int CODE_W  = mlsba_pkg::CODE_W;
  localparam int PROD_W  = COEF_W + CODE_W + 1;
  localparam int Q_W     = PROD_W + 1;
  localparam int DIV_CW  = $clog2(SUM_W + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_DIVA  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIVL  = 4'd6;
  localparam logic [3:0] S_DIVM  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Configuration registers.
  logic [CNT_W-1:0]         chan_count_r;
  logic [LEN_W-1:0]         avg_len_r;
  logic signed [COEF_W-1:0] gain_r;
  logic signed [COEF_W-1:0] offset_r;

  // Channel state, held in flops and read at the single index idx_r.
  logic [PCT_W-1:0] last_vals_r [MAX_CHANNELS];
  logic [SUM_W-1:0] sums_r      [MAX_CHANNELS];
  logic [PCT_W-1:0] avgs_r      [MAX_CHANNELS];
  logic [LEN_W-1:0] round_r;

  // Per-item working registers.
  logic [3:0]               state_r;
  logic [CH_W-1:0]          ch_r;
  logic [CODE_W-1:0]        code_r;
  logic [CH_W-1:0]          idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PCT_W-1:0]         value_r;
  logic                     updated_r;
  logic [PCT_W-1:0]         avg_out_r;
  logic [TOT_W-1:0]         tot_last_r;
  logic [TOT_W-1:0]         tot_avg_r;
  logic [PCT_W-1:0]         mean_last_r;

  // Shared divider.
  logic [SUM_W-1:0]  div_quo_r;
  logic [PCT_W-1:0]  div_rem_r;
  logic [LEN_W-1:0]  div_den_r;
  logic [DIV_CW-1:0] div_cnt_r;

  localparam int OUT_DATA_W_LOC = mlsba_pkg::OUT_DATA_W;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W_LOC-1:0] out_data_r;
  logic                  out_user_r;

  // Derived values.
  logic [CNT_W-1:0]  eff_count;
  logic [LEN_W-1:0]  blen;
  logic [IDX_W-1:0]  idx_a;
  logic              ch_stored;
  logic signed [Q_W-1:0] q_full;
  logic [PCT_W-1:0]  value_nxt;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_nxt;
  logic [LEN_W:0]    this_round;
  logic              avg_due;
  logic              last_of_round;
  logic              acc_last;
  logic [PCT_W:0]    div_trial;
  logic              div_ge;
  logic [PCT_W-1:0]  avg_sat;
  logic              accept;

  always_comb begin
    if (chan_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (chan_count_r > CNT_W'(MAX_CHANNELS)) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = chan_count_r;
    end
  end

  assign blen      = (avg_len_r == '0) ? LEN_W'(1) : avg_len_r;
  assign idx_a     = idx_r[IDX_W-1:0];
  assign ch_stored = ({1'b0, ch_r} < CNT_W'(MAX_CHANNELS));
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Fixed-point scaling: truncate the Q16.16 value, clamp to 0..255.
  assign q_full = $signed({prod_r[PROD_W-1], prod_r})
                + $signed({{(Q_W-COEF_W){offset_r[COEF_W-1]}}, offset_r});
  always_comb begin
    if (q_full[Q_W-1]) begin
      value_nxt = '0;
    end else if (|q_full[Q_W-2:16+PCT_W]) begin
      value_nxt = mlsba_pkg::PERCENT_CAP;
    end else begin
      value_nxt = q_full[16 +: PCT_W];
    end
  end

  // Running sum with saturation, and the round position of this sample.
  assign sum_raw       = {1'b0, sums_r[idx_a]} + (SUM_W+1)'(value_r);
  assign sum_nxt       = sum_raw[SUM_W] ? mlsba_pkg::SUM_CAP : sum_raw[SUM_W-1:0];
  assign this_round    = {1'b0, round_r} + (LEN_W+1)'(1);
  assign avg_due       = (this_round >= {1'b0, blen});
  assign last_of_round = ({1'b0, ch_r} == eff_count - CNT_W'(1));
  assign acc_last      = ({1'b0, idx_r} == eff_count - CNT_W'(1));

  // One restoring step: the remainder always stays below the divisor.
  assign div_trial = {div_rem_r, div_quo_r[SUM_W-1]} - {1'b0, div_den_r};
  assign div_ge    = !div_trial[PCT_W];
  assign avg_sat   = (|div_quo_r[SUM_W-1:PCT_W]) ? mlsba_pkg::PERCENT_CAP
                                                 : div_quo_r[PCT_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= mlsba_pkg::RST_CHANNEL_COUNT;
      avg_len_r    <= mlsba_pkg::RST_AVG_LENGTH;
      gain_r       <= mlsba_pkg::RST_GAIN;
      offset_r     <= mlsba_pkg::RST_OFFSET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mlsba_pkg::REG_CHANNEL_COUNT: chan_count_r <= cfg_wdata[CNT_W-1:0];
        mlsba_pkg::REG_AVG_LENGTH:    avg_len_r    <= cfg_wdata[LEN_W-1:0];
        mlsba_pkg::REG_GAIN:          gain_r       <= cfg_wdata;
        mlsba_pkg::REG_OFFSET:        offset_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer, channel state and the shared divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      round_r     <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        last_vals_r[i] <= '0;
        sums_r[i]      <= '0;
        avgs_r[i]      <= '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (div_cnt_r != '0) begin
        div_rem_r <= div_ge ? div_trial[PCT_W-1:0]
                            : {div_rem_r[PCT_W-2:0], div_quo_r[SUM_W-1]};
        div_quo_r <= {div_quo_r[SUM_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - DIV_CW'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            ch_r    <= in_tdata[CH_W-1:0];
            idx_r   <= in_tdata[CH_W-1:0];
            code_r  <= in_tdata[CH_W +: CODE_W];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(gain_r) * PROD_W'($signed({1'b0, code_r}));
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          value_r <= value_nxt;
          state_r <= S_UPD;
        end
        S_UPD: begin
          updated_r  <= 1'b0;
          avg_out_r  <= '0;
          tot_last_r <= '0;
          tot_avg_r  <= '0;
          state_r    <= S_ACC;
          if (ch_stored) begin
            last_vals_r[idx_a] <= value_r;
            avg_out_r          <= avgs_r[idx_a];
            if (avg_due) begin
              // Block complete: divide the sum, clear it for the next block.
              sums_r[idx_a] <= '0;
              updated_r     <= 1'b1;
              div_quo_r     <= sum_nxt;
              div_rem_r     <= '0;
              div_den_r     <= blen;
              div_cnt_r     <= DIV_CW'(SUM_W);
              state_r       <= S_DIVA;
            end else begin
              sums_r[idx_a] <= sum_nxt;
            end
            if (last_of_round) begin
              round_r <= avg_due ? '0 : this_round[LEN_W-1:0];
            end
          end
          if (!(ch_stored && avg_due)) begin
            idx_r <= '0;
          end
        end
        S_DIVA: begin
          if (div_cnt_r == '0) begin
            avgs_r[idx_a] <= avg_sat;
            avg_out_r     <= avg_sat;
            idx_r         <= '0;
            state_r       <= S_ACC;
          end
        end
        S_ACC: begin
          tot_last_r <= tot_last_r + TOT_W'(last_vals_r[idx_a]);
          tot_avg_r  <= tot_avg_r + TOT_W'(avgs_r[idx_a]);
          idx_r      <= idx_r + CH_W'(1);
          if (acc_last) begin
            div_quo_r <= SUM_W'(tot_last_r + TOT_W'(last_vals_r[idx_a]));
            div_rem_r <= '0;
            div_den_r <= LEN_W'(eff_count);
            div_cnt_r <= DIV_CW'(SUM_W);
            state_r   <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_cnt_r == '0) begin
            mean_last_r <= div_quo_r[PCT_W-1:0];
            div_quo_r   <= SUM_W'(tot_avg_r);
            div_rem_r   <= '0;
            div_cnt_r   <= DIV_CW'(SUM_W);
            state_r     <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= updated_r;
            out_data_r  <= {5'd0, div_quo_r[PCT_W-1:0], mean_last_r, avg_out_r,
                            value_r, ch_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The sequencer holds off new input until the current item has finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while an item was in progress");

  // The divider only runs inside one of the division states.
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div_cnt_r != '0) |-> (state_r == S_DIVA || state_r == S_DIVL ||
                           state_r == S_DIVM))
    else $error("divider stepping outside a division state");

  // A new average is only ever flagged for a channel that has storage.
  a_update_stored_ch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ({1'b0, out_tdata[CH_W-1:0]} < CNT_W'(MAX_CHANNELS)))
    else $error("average flagged for a channel without storage");

  // The totaling pass never indexes past the configured channel count.
  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> ({1'b0, idx_r} < eff_count))
    else $error("channel total index beyond channel count");

endmodule
`default_nettype wire

[tb/multichannel_linear_scale_block_average_tb.sv]
// Self-checking testbench for the multichannel linear scale and block average block.
module multichannel_linear_scale_block_average_tb;

  // Stop after this many cycles without any transaction or register write.
  // The slowest legitimate quiet stretch is the long receiver hold-off of
  // HOLD_CYCLES, so the limit leaves a wide margin above it.
  localparam int WATCHDOG_LIMIT = 5000;
  // Quiet cycles before a register write, and at the end of the run.
  localparam int SETTLE_CYCLES  = 80;
  // Length of the single long receiver hold-off.
  localparam int HOLD_CYCLES    = 600;

  typedef struct packed {
    logic [mlsba_pkg::CH_W-1:0]   channel;
    logic [mlsba_pkg::CODE_W-1:0] code;
  } sample_t;

  typedef struct packed {
    logic [mlsba_pkg::CH_W-1:0]  channel;
    logic [mlsba_pkg::PCT_W-1:0] last_value;
    logic                        avg_updated;
    logic [mlsba_pkg::PCT_W-1:0] average;
    logic [mlsba_pkg::PCT_W-1:0] last_mean;
    logic [mlsba_pkg::PCT_W-1:0] avg_mean;
  } percent_result_t;

  // Clock, reset and all block inputs start from known values.
  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // in_tdata fields from bit 0: channel[2:0], sample_code[14:3], zero pad.
  logic [mlsba_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // out_tdata fields from bit 0: channel_out[2:0], last_value[10:3],
  // channel_average[18:11], all_last_mean[26:19], all_average_mean[34:27].
  logic [mlsba_pkg::OUT_DATA_W-1:0] out_tdata;
  // out_tuser fields from bit 0: average_updated.
  logic                             out_tuser;
  logic                             cfg_we    = 1'b0;
  logic [mlsba_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [mlsba_pkg::COEF_W-1:0]     cfg_wdata = '0;

  // Samples waiting to be offered, and results predicted for accepted samples.
  sample_t         pending_samples[$];
  percent_result_t expected_results[$];

  // Idle behavior of both sides, in percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Toggled by the stimulus to start one long receiver hold-off.
  logic        hold_req       = 1'b0;
  int          error_count    = 0;

  // Predictor state: a copy of the registers and of the per-channel storage.
  logic [mlsba_pkg::COUNT_W-1:0] chan_count_r;
  logic [mlsba_pkg::LEN_W-1:0]   block_len_r;
  logic [mlsba_pkg::COEF_W-1:0]  gain_r;
  logic [mlsba_pkg::COEF_W-1:0]  offset_r;
  logic [mlsba_pkg::PCT_W-1:0]   last_pct   [mlsba_pkg::MAX_CHANNELS_DEF];
  logic [mlsba_pkg::SUM_W-1:0]   sum_pct    [mlsba_pkg::MAX_CHANNELS_DEF];
  logic [mlsba_pkg::PCT_W-1:0]   avg_pct    [mlsba_pkg::MAX_CHANNELS_DEF];
  logic [mlsba_pkg::LEN_W-1:0]   rounds_done;

  multichannel_linear_scale_block_average u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Channel count as the block uses it: zero counts as one, anything above
  // the storage depth counts as the full depth.
  function automatic int active_channels();
    if (chan_count_r == 0) return 1;
    if (chan_count_r > mlsba_pkg::MAX_CHANNELS_DEF) return mlsba_pkg::MAX_CHANNELS_DEF;
    return chan_count_r;
  endfunction

  // Signed Q16.16 gain times code plus offset, truncated to whole percent
  // and clamped to 0..255. A negative total always ends up as zero.
  function automatic logic [mlsba_pkg::PCT_W-1:0] scaled_percent(
    input logic [mlsba_pkg::CODE_W-1:0] code);
    longint q;
    q = longint'($signed(gain_r)) * longint'({20'd0, code}) + longint'($signed(offset_r));
    if (q < 0) return '0;
    if ((q >>> 16) > longint'(mlsba_pkg::PERCENT_CAP)) return mlsba_pkg::PERCENT_CAP;
    return q[23:16];
  endfunction

  function automatic void reset_predictor();
    chan_count_r = mlsba_pkg::RST_CHANNEL_COUNT;
    block_len_r  = mlsba_pkg::RST_AVG_LENGTH;
    gain_r       = mlsba_pkg::RST_GAIN;
    offset_r     = mlsba_pkg::RST_OFFSET;
    rounds_done  = '0;
    for (int i = 0; i < mlsba_pkg::MAX_CHANNELS_DEF; i++) begin
      last_pct[i] = '0;
      sum_pct[i]  = '0;
      avg_pct[i]  = '0;
    end
  endfunction

  // Advances the predicted state by one accepted sample and queues the
  // result the block must return for it.
  function automatic void absorb_sample(input sample_t s);
    percent_result_t r;
    int              count;
    int              blen;
    int              this_round;
    int unsigned     acc;
    int unsigned     quot;
    int unsigned     total_last;
    int unsigned     total_avg;
    logic [mlsba_pkg::PCT_W-1:0] v;
    count      = active_channels();
    blen       = (block_len_r == 0) ? 1 : block_len_r;
    v          = scaled_percent(s.code);
    acc        = sum_pct[s.channel] + v;
    this_round = rounds_done + 1;
    if (acc > mlsba_pkg::SUM_CAP) acc = mlsba_pkg::SUM_CAP;
    last_pct[s.channel] = v;
    r.avg_updated = 1'b0;
    // The averaging round also fires when the round counter already passed
    // a freshly lowered block length.
    if (this_round >= blen) begin
      quot = acc / blen;
      avg_pct[s.channel] = (quot > mlsba_pkg::PERCENT_CAP) ? mlsba_pkg::PERCENT_CAP
                                                           : quot[mlsba_pkg::PCT_W-1:0];
      sum_pct[s.channel] = '0;
      r.avg_updated = 1'b1;
    end else begin
      sum_pct[s.channel] = acc[mlsba_pkg::SUM_W-1:0];
    end
    // Only the highest configured channel closes a round; channels above
    // the count are stored and averaged but never close one.
    if (s.channel == count - 1)
      rounds_done = (this_round >= blen) ? '0 : this_round[mlsba_pkg::LEN_W-1:0];
    total_last = 0;
    total_avg  = 0;
    for (int i = 0; i < count; i++) begin
      total_last += last_pct[i];
      total_avg  += avg_pct[i];
    end
    total_last &= 11'h7FF;
    total_avg  &= 11'h7FF;
    r.channel    = s.channel;
    r.last_value = v;
    r.average    = avg_pct[s.channel];
    r.last_mean  = mlsba_pkg::PCT_W'(total_last / count);
    r.avg_mean   = mlsba_pkg::PCT_W'(total_avg / count);
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers the head of the pending queue. A held item stays on the bus
  // unchanged until it is taken; in_tvalid gets at most one assignment per edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_sample(pending_samples.pop_front());
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, pending_samples[0].code, pending_samples[0].channel};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, or one long hold-off counted here so the
  // block fills up while the driver keeps offering samples.
  int   hold_left = 0;
  logic hold_seen = 1'b0;

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result transaction is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    percent_result_t got;
    percent_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.channel     = out_tdata[2:0];
      got.last_value  = out_tdata[10:3];
      got.average     = out_tdata[18:11];
      got.last_mean   = out_tdata[26:19];
      got.avg_mean    = out_tdata[34:27];
      got.avg_updated = out_tuser;
      if (expected_results.size() == 0) begin
        report_mismatch("result without a pending sample, channel", got.channel, -1);
      end else begin
        want = expected_results.pop_front();
        if (got.channel !== want.channel)
          report_mismatch("channel_out", got.channel, want.channel);
        if (got.last_value !== want.last_value)
          report_mismatch("last_value", got.last_value, want.last_value);
        if (got.avg_updated !== want.avg_updated)
          report_mismatch("average_updated", got.avg_updated, want.avg_updated);
        if (got.average !== want.average)
          report_mismatch("channel_average", got.average, want.average);
        if (got.last_mean !== want.last_mean)
          report_mismatch("all_last_mean", got.last_mean, want.last_mean);
        if (got.avg_mean !== want.avg_mean)
          report_mismatch("all_average_mean", got.avg_mean, want.avg_mean);
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_sample(input int ch, input int code);
    sample_t s;
    s.channel = ch[mlsba_pkg::CH_W-1:0];
    s.code    = code[mlsba_pkg::CODE_W-1:0];
    pending_samples.push_back(s);
  endtask

  // Waits at falling edges until every sample went in and every result
  // came back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [mlsba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mlsba_pkg::COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      mlsba_pkg::REG_CHANNEL_COUNT: chan_count_r = val[mlsba_pkg::COUNT_W-1:0];
      mlsba_pkg::REG_AVG_LENGTH:    block_len_r  = val[mlsba_pkg::LEN_W-1:0];
      mlsba_pkg::REG_GAIN:          gain_r       = val;
      mlsba_pkg::REG_OFFSET:        offset_r     = val;
      default: ;
    endcase
  endtask

  // Registers change only with the block empty and settled. Ends at a
  // falling edge so the caller can refill the queue without racing the driver.
  task automatic configure(input logic [mlsba_pkg::COEF_W-1:0] count,
                           input logic [mlsba_pkg::COEF_W-1:0] len,
                           input logic [mlsba_pkg::COEF_W-1:0] gain,
                           input logic [mlsba_pkg::COEF_W-1:0] offset);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(mlsba_pkg::REG_CHANNEL_COUNT, count);
    write_reg(mlsba_pkg::REG_AVG_LENGTH, len);
    write_reg(mlsba_pkg::REG_GAIN, gain);
    write_reg(mlsba_pkg::REG_OFFSET, offset);
    @(negedge clk);
  endtask

  // Mostly complete rounds in channel order; about one sample in ten goes to
  // a random channel and one in twenty is dropped to break a round.
  task automatic fill_rounds(input int n);
    int pushed;
    int ch;
    int code;
    pushed = 0;
    while (pushed < n) begin
      for (int c = 0; c < active_channels() && pushed < n; c++) begin
        if ($urandom_range(19) != 0) begin
          ch = ($urandom_range(9) == 0) ?
               $urandom_range(mlsba_pkg::MAX_CHANNELS_DEF - 1) : c;
          case ($urandom_range(9))
            0:       code = 0;
            1:       code = 4095;
            default: code = $urandom_range(4095);
          endcase
          push_sample(ch, code);
          pushed++;
        end
      end
    end
  endtask

  // Idle modes: none, sender idle, receiver stalling, both lightly.
  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_sequence
    int          p;
    logic [31:0] count_v;
    logic [31:0] len_v;
    logic [31:0] gain_v;
    logic [31:0] offset_v;
    reset_predictor();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: one channel, block of one, unity gain. Covers the code
    // extremes, the step across 255 and a channel above the count.
    push_sample(0, 0);
    push_sample(0, 255);
    push_sample(0, 256);
    push_sample(0, 4095);
    push_sample(7, 4095);
    push_sample(0, 100);

    // Count of zero and block length of zero both act as one; half gain and
    // a negative offset check truncation and clamping at zero.
    configure(0, 0, 32'h0000_8000, -(32'sd3 <<< 16) + 32'sh8000);
    push_sample(0, 0);
    push_sample(0, 6);
    push_sample(0, 7);
    push_sample(3, 4095);

    // Two rounds of a ten-round block, then the block length drops to the round
    // counter and the next round averages at once.
    configure(3, 10, 32'h0001_0000, 0);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        push_sample(c, 40 * r + 10 * c + 5);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(mlsba_pkg::REG_AVG_LENGTH, 2);
    @(negedge clk);
    push_sample(0, 200);
    push_sample(1, 17);

    // A channel above the count takes several samples per round, at a gain
    // that drives every scaled value to the 255 clamp.
    configure(1, 2, 32'h7FFF_FFFF, 0);
    push_sample(3, 4095);
    push_sample(3, 1);
    push_sample(3, 2048);
    push_sample(0, 9);
    push_sample(3, 77);

    // Random phases with rotating settings and idle modes.
    for (p = 0; p < 12; p++) begin
      case (p)
        1:       count_v = 15;
        2:       count_v = 0;
        3:       count_v = 8;
        8:       count_v = 9;
        default: count_v = $urandom_range(1, 8);
      endcase
      case (p)
        0:       len_v = 1;
        1:       len_v = 255;
        2:       len_v = 0;
        default: len_v = $urandom_range(1, 6);
      endcase
      if (p == 5) begin
        gain_v   = 32'h7FFF_FFFF;
        offset_v = 32'h8000_0000;
      end else if (p == 6) begin
        gain_v   = 32'h8000_0000;
        offset_v = 32'h7FFF_FFFF;
      end else if (p % 3 == 0) begin
        gain_v   = $urandom;
        offset_v = $urandom;
      end else begin
        gain_v   = $urandom_range(0, 6000);
        offset_v = $urandom_range(0, 120 << 16) - (20 << 16);
      end
      configure(count_v, len_v, gain_v, offset_v);
      set_idle_mode(p % 4);
      // One long receiver hold-off while the driver keeps pushing.
      if (p == 3) hold_req = ~hold_req;
      if (p == 7) begin
        // The sender pauses mid-phase until every result is back.
        fill_rounds(45);
        wait_drained();
        fill_rounds(45);
      end else begin
        fill_rounds(90);
      end
    end

    // Sum saturation: a channel above the count gathers more than 65535
    // within one 255-round block, then the round channel finishes.
    configure(1, 255, 32'h7FFF_FFFF, 0);
    set_idle_mode(0);
    repeat (260) push_sample(5, $urandom_range(1, 4095));
    repeat (10) push_sample(0, $urandom_range(4095));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
